// ----- sv/hac_pkg.sv -----
`default_nettype none

package hac_pkg;

    localparam int ROOT_INDEX  = 512;
    localparam int NODES       = ROOT_INDEX + 1;
    localparam int NODE_AW     = $clog2(NODES);
    localparam int IDX_W       = 11;
    localparam int SYM_W       = 8;
    localparam int SYMBOLS     = 1 << SYM_W;
    localparam int WEIGHT_W    = 32;
    localparam int CHUNK_BITS  = 32;
    localparam int CHUNK_EFF   = (CHUNK_BITS > 32) ? 32 : CHUNK_BITS;
    localparam int MAX_RESULTS = 9;
    localparam int BUF_BITS    = CHUNK_EFF * MAX_RESULTS;
    localparam int LEN_W       = $clog2(NODES + SYM_W + 1);
    localparam int REM_W       = $clog2(BUF_BITS + 1);
    localparam int GUARD_MAX   = 2 * NODES;
    localparam int GUARD_W     = $clog2(GUARD_MAX + 1);
    localparam int CNT_W       = 4;

    localparam logic [IDX_W-1:0] NONE_IDX = '1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             code_bit;
    } item_t;

    typedef struct packed {
        logic [31:0]      code_bits;
        logic [5:0]       code_len;
        logic [SYM_W-1:0] symbol_out;
        logic             symbol_valid;
        logic             last;
        logic             weight_overflow;
    } result_t;

    typedef struct packed {
        logic [IDX_W-1:0]    left;
        logic [IDX_W-1:0]    right;
        logic [WEIGHT_W-1:0] weight;
        logic [SYM_W-1:0]    symbol;
    } node_body_t;

    localparam node_body_t BODY_EMPTY = '{left: NONE_IDX, right: NONE_IDX,
                                          weight: '0, symbol: '0};

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR,
        OP_ACCEPT,
        OP_E_LRD,
        OP_E_LCHK,
        OP_C_RD,
        OP_C_PAR,
        OP_C_BIT,
        OP_E_POST,
        OP_SP_RD,
        OP_SP_W0,
        OP_SP_W1,
        OP_SP_W2,
        OP_R_START,
        OP_R_LATA,
        OP_S_RD,
        OP_S_CHK,
        OP_W1A,
        OP_W1B,
        OP_W2A,
        OP_W2B,
        OP_W3,
        OP_INC,
        OP_R_NEXT,
        OP_FIN,
        OP_D_START,
        OP_D_LRD,
        OP_D_LCHK,
        OP_D_WCHK,
        OP_D_NCHK,
        OP_EMIT_NEXT
    } op_t;

    typedef struct packed {
        logic clr_done;
        logic cfg_mode;
        logic item_mode;
        logic leaf_ok;
        logic pos_ok;
        logic p_ok;
        logic known;
        logic nyt_lt2;
        logic guard_end;
        logic np_end;
        logic w_eq;
        logic swap;
        logic reading;
        logic lit_full;
        logic nx_go;
        logic n_leaf;
        logic emit_last;
    } status_t;

    function automatic logic idx_ok(input logic [IDX_W-1:0] i);
        return i < IDX_W'(NODES);
    endfunction

    function automatic logic body_is_leaf(input node_body_t b);
        return (b.left == NONE_IDX) && (b.right == NONE_IDX);
    endfunction

endpackage

`default_nettype wire

// ----- sv/hac_ram.sv -----
`default_nettype none

module hac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/hac_datapath.sv -----
`default_nettype none

module hac_datapath
    import hac_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire op_t     op,
    output status_t      status,
    input  wire item_t   item,
    input  wire logic    cfg_we,
    input  wire logic    cfg_wdata,
    output result_t      result
);

    logic                  mode_reg, mode_next;
    logic [NODE_AW-1:0]    nyt_reg, nyt_next;
    logic [NODE_AW-1:0]    walk_reg, walk_next;
    logic [SYM_W-1:0]      lit_shift_reg, lit_shift_next;
    logic [CNT_W-1:0]      lit_cnt_reg, lit_cnt_next;
    logic                  reading_reg, reading_next;
    logic [NODE_AW-1:0]    clr_idx_reg, clr_idx_next;

    logic                  item_mode_reg, item_mode_next;
    logic [SYM_W-1:0]      sym_reg, sym_next;
    logic                  bit_reg, bit_next;
    logic                  sym_valid_reg, sym_valid_next;
    logic                  ovf_reg, ovf_next;
    logic                  known_reg, known_next;
    logic [IDX_W-1:0]      tgt_reg, tgt_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [IDX_W-1:0]      p_reg, p_next;
    logic [NODE_AW-1:0]    np_reg, np_next;
    node_body_t            a_reg, a_next;
    logic [IDX_W-1:0]      a_par_reg, a_par_next;
    node_body_t            b_reg, b_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LEN_W-1:0]      depth_reg, depth_next;
    logic [GUARD_W-1:0]    guard_reg, guard_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [BUF_BITS-1:0]   path_reg, path_next;

    logic                  body_we;
    logic [NODE_AW-1:0]    body_waddr;
    node_body_t            body_wdata;
    logic [NODE_AW-1:0]    body_raddr;
    logic [$bits(node_body_t)-1:0] body_rd;
    node_body_t            body_q;

    logic                  parent_we;
    logic [NODE_AW-1:0]    parent_waddr;
    logic [IDX_W-1:0]      parent_wdata;
    logic [NODE_AW-1:0]    parent_raddr;
    logic [IDX_W-1:0]      parent_q;

    logic                  leaf_we;
    logic [SYM_W-1:0]      leaf_waddr;
    logic [IDX_W-1:0]      leaf_wdata;
    logic [SYM_W-1:0]      leaf_raddr;
    logic [IDX_W-1:0]      leaf_q;

    logic [IDX_W-1:0]      nx;
    logic [SYM_W-1:0]      lit_shift_in;
    logic [REM_W-1:0]      chunk_n;
    logic [CHUNK_EFF-1:0]  chunk_top;
    node_body_t            a_inc;

    hac_ram #(.WIDTH($bits(node_body_t)), .DEPTH(NODES)) u_body_ram (
        .clk   (clk),
        .we    (body_we),
        .waddr (body_waddr),
        .wdata (body_wdata),
        .raddr (body_raddr),
        .rdata (body_rd)
    );

    hac_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_parent_ram (
        .clk   (clk),
        .we    (parent_we),
        .waddr (parent_waddr),
        .wdata (parent_wdata),
        .raddr (parent_raddr),
        .rdata (parent_q)
    );

    hac_ram #(.WIDTH(IDX_W), .DEPTH(SYMBOLS)) u_leaf_ram (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (leaf_waddr),
        .wdata (leaf_wdata),
        .raddr (leaf_raddr),
        .rdata (leaf_q)
    );

    assign body_q       = node_body_t'(body_rd);
    assign nx           = bit_reg ? body_q.right : body_q.left;
    assign lit_shift_in = {lit_shift_reg[SYM_W-2:0], bit_reg};
    assign chunk_n      = (rem_reg > REM_W'(CHUNK_EFF)) ? REM_W'(CHUNK_EFF) : rem_reg;
    assign chunk_top    = path_reg[BUF_BITS-1 -: CHUNK_EFF];

    always_comb
    begin
        a_inc = a_reg;
        a_inc.weight = a_reg.weight + 1'b1;
    end

    always_comb
    begin
        status.clr_done  = clr_idx_reg == NODE_AW'(NODES - 1);
        status.cfg_mode  = mode_reg;
        status.item_mode = item_mode_reg;
        status.leaf_ok   = idx_ok(leaf_q);
        status.pos_ok    = idx_ok(pos_reg);
        status.p_ok      = idx_ok(parent_q) && (depth_reg < LEN_W'(NODES));
        status.known     = known_reg;
        status.nyt_lt2   = nyt_reg < NODE_AW'(2);
        status.guard_end = guard_reg >= GUARD_W'(GUARD_MAX);
        status.np_end    = (IDX_W'(np_reg) + 1'b1) >= IDX_W'(NODES);
        status.w_eq      = body_q.weight == a_reg.weight;
        status.swap      = (IDX_W'(np_reg) != pos_reg) && (IDX_W'(np_reg) != a_par_reg);
        status.reading   = reading_reg;
        status.lit_full  = lit_cnt_reg == CNT_W'(SYM_W - 1);
        status.nx_go     = idx_ok(nx) && (nx != IDX_W'(nyt_reg));
        status.n_leaf    = body_is_leaf(body_q);
        status.emit_last = rem_reg <= REM_W'(CHUNK_EFF);
    end

    always_comb
    begin
        mode_next      = cfg_we ? cfg_wdata : mode_reg;
        nyt_next       = nyt_reg;
        walk_next      = walk_reg;
        lit_shift_next = lit_shift_reg;
        lit_cnt_next   = lit_cnt_reg;
        reading_next   = reading_reg;
        clr_idx_next   = clr_idx_reg;
        item_mode_next = item_mode_reg;
        sym_next       = sym_reg;
        bit_next       = bit_reg;
        sym_valid_next = sym_valid_reg;
        ovf_next       = ovf_reg;
        known_next     = known_reg;
        tgt_next       = tgt_reg;
        pos_next       = pos_reg;
        p_next         = p_reg;
        np_next        = np_reg;
        a_next         = a_reg;
        a_par_next     = a_par_reg;
        b_next         = b_reg;
        len_next       = len_reg;
        depth_next     = depth_reg;
        guard_next     = guard_reg;
        rem_next       = rem_reg;
        path_next      = path_reg;

        body_we      = 1'b0;
        body_waddr   = pos_reg[NODE_AW-1:0];
        body_wdata   = a_inc;
        body_raddr   = pos_reg[NODE_AW-1:0];
        parent_we    = 1'b0;
        parent_waddr = b_reg.left[NODE_AW-1:0];
        parent_wdata = pos_reg;
        parent_raddr = pos_reg[NODE_AW-1:0];
        leaf_we      = 1'b0;
        leaf_waddr   = b_reg.symbol;
        leaf_wdata   = pos_reg;
        leaf_raddr   = sym_reg;

        unique case (op)
            OP_CLR:
            begin
                body_we      = 1'b1;
                body_waddr   = clr_idx_reg;
                body_wdata   = BODY_EMPTY;
                parent_we    = 1'b1;
                parent_waddr = clr_idx_reg;
                parent_wdata = NONE_IDX;
                leaf_we      = clr_idx_reg < NODE_AW'(SYMBOLS);
                leaf_waddr   = clr_idx_reg[SYM_W-1:0];
                leaf_wdata   = NONE_IDX;
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            OP_ACCEPT:
            begin
                item_mode_next = mode_reg;
                sym_next       = item.symbol;
                bit_next       = item.code_bit;
                sym_valid_next = 1'b0;
                ovf_next       = 1'b0;
                len_next       = '0;
                depth_next     = '0;
                guard_next     = '0;
            end
            OP_E_LRD:
            begin
                leaf_raddr = sym_reg;
            end
            OP_E_LCHK:
            begin
                if (idx_ok(leaf_q))
                begin
                    known_next = 1'b1;
                    tgt_next   = leaf_q;
                    pos_next   = leaf_q;
                end
                else
                begin
                    known_next = 1'b0;
                    pos_next   = IDX_W'(nyt_reg);
                    path_next  = {sym_reg, path_reg[BUF_BITS-1:SYM_W]};
                    len_next   = LEN_W'(SYM_W);
                end
            end
            OP_C_RD:
            begin
                parent_raddr = pos_reg[NODE_AW-1:0];
            end
            OP_C_PAR:
            begin
                body_raddr = parent_q[NODE_AW-1:0];
                p_next     = parent_q;
            end
            OP_C_BIT:
            begin
                path_next  = {body_q.left != pos_reg, path_reg[BUF_BITS-1:1]};
                len_next   = len_reg + 1'b1;
                depth_next = depth_reg + 1'b1;
                pos_next   = p_reg;
            end
            OP_E_POST:
            begin
                pos_next = tgt_reg;
            end
            OP_SP_RD:
            begin
                body_raddr = nyt_reg;
            end
            OP_SP_W0:
            begin
                body_we           = 1'b1;
                body_waddr        = nyt_reg;
                body_wdata        = body_q;
                body_wdata.left   = IDX_W'(nyt_reg - NODE_AW'(2));
                body_wdata.right  = IDX_W'(nyt_reg - NODE_AW'(1));
                leaf_we           = 1'b1;
                leaf_waddr        = sym_reg;
                leaf_wdata        = IDX_W'(nyt_reg - NODE_AW'(1));
                parent_we         = 1'b1;
                parent_waddr      = nyt_reg - NODE_AW'(1);
                parent_wdata      = IDX_W'(nyt_reg);
            end
            OP_SP_W1:
            begin
                body_we           = 1'b1;
                body_waddr        = nyt_reg - NODE_AW'(1);
                body_wdata        = BODY_EMPTY;
                body_wdata.symbol = sym_reg;
                parent_we         = 1'b1;
                parent_waddr      = nyt_reg - NODE_AW'(2);
                parent_wdata      = IDX_W'(nyt_reg);
            end
            OP_SP_W2:
            begin
                body_we    = 1'b1;
                body_waddr = nyt_reg - NODE_AW'(2);
                body_wdata = BODY_EMPTY;
                nyt_next   = nyt_reg - NODE_AW'(2);
                pos_next   = IDX_W'(nyt_reg - NODE_AW'(1));
            end
            OP_R_START:
            begin
                guard_next   = guard_reg + 1'b1;
                body_raddr   = pos_reg[NODE_AW-1:0];
                parent_raddr = pos_reg[NODE_AW-1:0];
            end
            OP_R_LATA:
            begin
                a_next     = body_q;
                b_next     = body_q;
                a_par_next = parent_q;
                np_next    = pos_reg[NODE_AW-1:0];
            end
            OP_S_RD:
            begin
                body_raddr = np_reg + 1'b1;
            end
            OP_S_CHK:
            begin
                if (body_q.weight == a_reg.weight)
                begin
                    b_next  = body_q;
                    np_next = np_reg + 1'b1;
                end
            end
            OP_W1A:
            begin
                if (body_is_leaf(b_reg))
                begin
                    leaf_we    = np_reg != nyt_reg;
                    leaf_waddr = b_reg.symbol;
                    leaf_wdata = pos_reg;
                end
                else
                begin
                    parent_we    = idx_ok(b_reg.left);
                    parent_waddr = b_reg.left[NODE_AW-1:0];
                    parent_wdata = pos_reg;
                end
            end
            OP_W1B:
            begin
                parent_we    = !body_is_leaf(b_reg) && idx_ok(b_reg.right);
                parent_waddr = b_reg.right[NODE_AW-1:0];
                parent_wdata = pos_reg;
            end
            OP_W2A:
            begin
                if (body_is_leaf(a_reg))
                begin
                    leaf_we    = pos_reg != IDX_W'(nyt_reg);
                    leaf_waddr = a_reg.symbol;
                    leaf_wdata = IDX_W'(np_reg);
                end
                else
                begin
                    parent_we    = idx_ok(a_reg.left);
                    parent_waddr = a_reg.left[NODE_AW-1:0];
                    parent_wdata = IDX_W'(np_reg);
                end
            end
            OP_W2B:
            begin
                parent_we    = !body_is_leaf(a_reg) && idx_ok(a_reg.right);
                parent_waddr = a_reg.right[NODE_AW-1:0];
                parent_wdata = IDX_W'(np_reg);
            end
            OP_W3:
            begin
                body_we    = 1'b1;
                body_waddr = pos_reg[NODE_AW-1:0];
                body_wdata = b_reg;
                pos_next   = IDX_W'(np_reg);
            end
            OP_INC:
            begin
                body_we    = 1'b1;
                body_waddr = pos_reg[NODE_AW-1:0];
                if (a_reg.weight == WEIGHT_MAX)
                begin
                    ovf_next   = 1'b1;
                    body_wdata = a_reg;
                end
                else
                begin
                    body_wdata = a_inc;
                end
                parent_raddr = pos_reg[NODE_AW-1:0];
            end
            OP_R_NEXT:
            begin
                pos_next = parent_q;
            end
            OP_FIN:
            begin
                rem_next = (len_reg > LEN_W'(BUF_BITS)) ? REM_W'(BUF_BITS) : REM_W'(len_reg);
            end
            OP_D_START:
            begin
                body_raddr = walk_reg;
                if (reading_reg)
                begin
                    if (lit_cnt_reg == CNT_W'(SYM_W - 1))
                    begin
                        sym_next       = lit_shift_in;
                        sym_valid_next = 1'b1;
                        reading_next   = 1'b0;
                        lit_cnt_next   = '0;
                        lit_shift_next = '0;
                        walk_next      = NODE_AW'(ROOT_INDEX);
                    end
                    else
                    begin
                        lit_shift_next = lit_shift_in;
                        lit_cnt_next   = lit_cnt_reg + 1'b1;
                    end
                end
            end
            OP_D_LRD:
            begin
                leaf_raddr = sym_reg;
            end
            OP_D_LCHK:
            begin
                pos_next = leaf_q;
            end
            OP_D_WCHK:
            begin
                body_raddr = nx[NODE_AW-1:0];
                pos_next   = nx;
                if (!idx_ok(nx))
                begin
                    walk_next = NODE_AW'(ROOT_INDEX);
                end
                else if (nx == IDX_W'(nyt_reg))
                begin
                    reading_next   = 1'b1;
                    lit_cnt_next   = '0;
                    lit_shift_next = '0;
                    walk_next      = NODE_AW'(ROOT_INDEX);
                end
            end
            OP_D_NCHK:
            begin
                if (body_is_leaf(body_q))
                begin
                    sym_next       = body_q.symbol;
                    sym_valid_next = 1'b1;
                    walk_next      = NODE_AW'(ROOT_INDEX);
                end
                else
                begin
                    walk_next = pos_reg[NODE_AW-1:0];
                end
            end
            OP_EMIT_NEXT:
            begin
                path_next = path_reg << CHUNK_EFF;
                rem_next  = rem_reg - chunk_n;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            nyt_reg       <= NODE_AW'(ROOT_INDEX);
            walk_reg      <= NODE_AW'(ROOT_INDEX);
            lit_shift_reg <= '0;
            lit_cnt_reg   <= '0;
            reading_reg   <= 1'b1;
            clr_idx_reg   <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            nyt_reg       <= nyt_next;
            walk_reg      <= walk_next;
            lit_shift_reg <= lit_shift_next;
            lit_cnt_reg   <= lit_cnt_next;
            reading_reg   <= reading_next;
            clr_idx_reg   <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_mode_reg <= item_mode_next;
        sym_reg       <= sym_next;
        bit_reg       <= bit_next;
        sym_valid_reg <= sym_valid_next;
        ovf_reg       <= ovf_next;
        known_reg     <= known_next;
        tgt_reg       <= tgt_next;
        pos_reg       <= pos_next;
        p_reg         <= p_next;
        np_reg        <= np_next;
        a_reg         <= a_next;
        a_par_reg     <= a_par_next;
        b_reg         <= b_next;
        len_reg       <= len_next;
        depth_reg     <= depth_next;
        guard_reg     <= guard_next;
        rem_reg       <= rem_next;
        path_reg      <= path_next;
    end

    always_comb
    begin
        result.code_bits       = '0;
        result.code_len        = '0;
        result.symbol_out      = '0;
        result.symbol_valid    = 1'b0;
        result.last            = 1'b1;
        result.weight_overflow = ovf_reg;
        if (item_mode_reg)
        begin
            result.symbol_out   = sym_valid_reg ? sym_reg : '0;
            result.symbol_valid = sym_valid_reg;
        end
        else
        begin
            result.code_bits = 32'(chunk_top >> (REM_W'(CHUNK_EFF) - chunk_n));
            result.code_len  = 6'(chunk_n);
            result.last      = rem_reg <= REM_W'(CHUNK_EFF);
        end
    end

endmodule

`default_nettype wire

// ----- sv/hac_ctrl.sv -----
`default_nettype none

module hac_ctrl
    import hac_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    input  wire logic    result_stall,
    input  wire status_t status,
    output op_t          op,
    output logic         item_stall,
    output logic         result_valid
);

    typedef enum logic [31:0] {
        S_CLR     = 32'h0000_0001,
        S_IDLE    = 32'h0000_0002,
        S_E_LRD   = 32'h0000_0004,
        S_E_LCHK  = 32'h0000_0008,
        S_C_RD    = 32'h0000_0010,
        S_C_PAR   = 32'h0000_0020,
        S_C_BIT   = 32'h0000_0040,
        S_E_POST  = 32'h0000_0080,
        S_SP_RD   = 32'h0000_0100,
        S_SP_W0   = 32'h0000_0200,
        S_SP_W1   = 32'h0000_0400,
        S_SP_W2   = 32'h0000_0800,
        S_R_START = 32'h0000_1000,
        S_R_LATA  = 32'h0000_2000,
        S_S_RD    = 32'h0000_4000,
        S_S_CHK   = 32'h0000_8000,
        S_S_END   = 32'h0001_0000,
        S_W1A     = 32'h0002_0000,
        S_W1B     = 32'h0004_0000,
        S_W2A     = 32'h0008_0000,
        S_W2B     = 32'h0010_0000,
        S_W3      = 32'h0020_0000,
        S_INC     = 32'h0040_0000,
        S_R_NEXT  = 32'h0080_0000,
        S_FIN     = 32'h0100_0000,
        S_D_START = 32'h0200_0000,
        S_D_LRD   = 32'h0400_0000,
        S_D_LCHK  = 32'h0800_0000,
        S_D_WCHK  = 32'h1000_0000,
        S_D_NCHK  = 32'h2000_0000,
        S_OUT     = 32'h4000_0000,
        S_EMIT    = 32'h8000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_CLR:
            begin
                op = OP_CLR;
                if (status.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op         = OP_ACCEPT;
                    state_next = status.cfg_mode ? S_D_START : S_E_LRD;
                end
            end
            S_E_LRD:
            begin
                op         = OP_E_LRD;
                state_next = S_E_LCHK;
            end
            S_E_LCHK:
            begin
                op         = OP_E_LCHK;
                state_next = S_C_RD;
            end
            S_C_RD:
            begin
                op         = OP_C_RD;
                state_next = status.pos_ok ? S_C_PAR : S_E_POST;
            end
            S_C_PAR:
            begin
                op         = OP_C_PAR;
                state_next = status.p_ok ? S_C_BIT : S_E_POST;
            end
            S_C_BIT:
            begin
                op         = OP_C_BIT;
                state_next = S_C_RD;
            end
            S_E_POST:
            begin
                op         = OP_E_POST;
                state_next = status.known ? S_R_START : S_SP_RD;
            end
            S_SP_RD:
            begin
                op         = OP_SP_RD;
                state_next = status.nyt_lt2 ? S_FIN : S_SP_W0;
            end
            S_SP_W0:
            begin
                op         = OP_SP_W0;
                state_next = S_SP_W1;
            end
            S_SP_W1:
            begin
                op         = OP_SP_W1;
                state_next = S_SP_W2;
            end
            S_SP_W2:
            begin
                op         = OP_SP_W2;
                state_next = S_R_START;
            end
            S_R_START:
            begin
                op         = OP_R_START;
                state_next = (!status.pos_ok || status.guard_end) ? S_FIN : S_R_LATA;
            end
            S_R_LATA:
            begin
                op         = OP_R_LATA;
                state_next = S_S_RD;
            end
            S_S_RD:
            begin
                op         = OP_S_RD;
                state_next = status.np_end ? S_S_END : S_S_CHK;
            end
            S_S_CHK:
            begin
                op         = OP_S_CHK;
                state_next = status.w_eq ? S_S_RD : S_S_END;
            end
            S_S_END:
            begin
                state_next = status.swap ? S_W1A : S_INC;
            end
            S_W1A:
            begin
                op         = OP_W1A;
                state_next = S_W1B;
            end
            S_W1B:
            begin
                op         = OP_W1B;
                state_next = S_W2A;
            end
            S_W2A:
            begin
                op         = OP_W2A;
                state_next = S_W2B;
            end
            S_W2B:
            begin
                op         = OP_W2B;
                state_next = S_W3;
            end
            S_W3:
            begin
                op         = OP_W3;
                state_next = S_INC;
            end
            S_INC:
            begin
                op         = OP_INC;
                state_next = S_R_NEXT;
            end
            S_R_NEXT:
            begin
                op         = OP_R_NEXT;
                state_next = S_R_START;
            end
            S_FIN:
            begin
                op         = OP_FIN;
                state_next = status.item_mode ? S_OUT : S_EMIT;
            end
            S_D_START:
            begin
                op = OP_D_START;
                if (status.reading)
                begin
                    state_next = status.lit_full ? S_D_LRD : S_OUT;
                end
                else
                begin
                    state_next = S_D_WCHK;
                end
            end
            S_D_LRD:
            begin
                op         = OP_D_LRD;
                state_next = S_D_LCHK;
            end
            S_D_LCHK:
            begin
                op         = OP_D_LCHK;
                state_next = status.leaf_ok ? S_R_START : S_SP_RD;
            end
            S_D_WCHK:
            begin
                op         = OP_D_WCHK;
                state_next = status.nx_go ? S_D_NCHK : S_OUT;
            end
            S_D_NCHK:
            begin
                op         = OP_D_NCHK;
                state_next = status.n_leaf ? S_R_START : S_OUT;
            end
            S_OUT:
            begin
                if (!result_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (!result_stall)
                begin
                    op         = OP_EMIT_NEXT;
                    state_next = status.emit_last ? S_IDLE : S_EMIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall   = state_reg != S_IDLE;
    assign result_valid = (state_reg == S_OUT) || (state_reg == S_EMIT);

endmodule

`default_nettype wire

// ----- sv/adaptive_huffman_codec_core.sv -----
// Adaptive Huffman codec core. The request channel (item_valid, item_stall,
// item) takes one byte to encode or one code bit to decode; the result
// channel (result_valid, result_stall, result) returns what that request
// causes. The user must write the mode register (cfg_we, cfg_wdata) only
// while the core is idle; the core does not enforce this. One request is
// handled at a time: item_stall is low only while the core waits for a new
// request. Encode returns one to nine result chunks of up to 32 code bits,
// the last one marked by last. Decode returns exactly one result per code
// bit. The node memory port does one read per cycle. The core forms the
// code by walking up from its leaf or the NYT node, one bit per tree level,
// splits the NYT node for a new symbol, then at each level of the weight
// update scans the nodes of equal weight, swaps the node when needed and
// increments its weight. A decode request that only moves the walk one
// level passes S_D_START, S_D_WCHK and S_D_NCHK before its result shows;
// one that adds a literal bit shows its result after S_D_START. After the
// last result the core returns to idle to take the next request. After
// reset it clears the node and symbol tables before item_stall drops. While
// the receiver stalls, the result holds steady and no new request is taken.
`default_nettype none

module adaptive_huffman_codec_core
    import hac_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result,
    input  wire logic    cfg_we,
    input  wire logic    cfg_wdata
);

    op_t     op;
    status_t status;

    hac_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .result_stall (result_stall),
        .status       (status),
        .op           (op),
        .item_stall   (item_stall),
        .result_valid (result_valid)
    );

    hac_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |-> !result_valid)
        else $error("request taken while a result is pending");

    a_decode_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.symbol_valid) |-> (result.code_len == 6'd0 && result.last))
        else $error("decoded symbol carries code bits");

    a_chunks_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !result.last) |=> result_valid)
        else $error("result chunks broken off before the last one");

endmodule

`default_nettype wire

// ----- bench/adaptive_huffman_codec_core_tb.sv -----
`timescale 1ns / 1ps

module adaptive_huffman_codec_core_tb
    import hac_pkg::*;
;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;
    logic    cfg_we = 1'b0;
    logic    cfg_wdata = 1'b0;

    adaptive_huffman_codec_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Tree state mirrored for prediction.
    logic [IDX_W-1:0]    t_parent [NODES];
    logic [IDX_W-1:0]    t_left   [NODES];
    logic [IDX_W-1:0]    t_right  [NODES];
    logic [WEIGHT_W-1:0] t_weight [NODES];
    logic [SYM_W-1:0]    t_symbol [NODES];
    logic [IDX_W-1:0]    sym_leaf [SYMBOLS];
    logic [IDX_W-1:0]    nyt;
    logic [IDX_W-1:0]    walk;
    logic [7:0]          lit_shift;
    logic [3:0]          lit_count;
    logic                in_literal;
    logic                codec_mode;

    result_t expected_results[$];
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;

    function automatic bit is_leaf_node(int i);
        return t_left[i] == NONE_IDX && t_right[i] == NONE_IDX;
    endfunction

    function automatic void tree_reset();
        for (int i = 0; i < NODES; i++) begin
            t_parent[i] = NONE_IDX;
            t_left[i] = NONE_IDX;
            t_right[i] = NONE_IDX;
            t_weight[i] = '0;
            t_symbol[i] = '0;
        end
        for (int i = 0; i < SYMBOLS; i++) sym_leaf[i] = NONE_IDX;
        nyt = IDX_W'(ROOT_INDEX);
        walk = IDX_W'(ROOT_INDEX);
        lit_shift = '0;
        lit_count = '0;
        in_literal = 1'b1;
        codec_mode = 1'b0;
    endfunction

    function automatic bit split_nyt_node(logic [7:0] s);
        int n;
        n = nyt;
        if (n < 2 || n >= NODES) return 1'b0;
        t_right[n] = IDX_W'(n - 1);
        t_left[n] = IDX_W'(n - 2);
        sym_leaf[s] = IDX_W'(n - 1);
        t_symbol[n - 1] = s;
        t_parent[n - 1] = IDX_W'(n);
        t_symbol[n - 2] = '0;
        t_parent[n - 2] = IDX_W'(n);
        nyt = IDX_W'(n - 2);
        return 1'b1;
    endfunction

    function automatic bit update_weights(int pos);
        bit                  ovf;
        int                  guard;
        int                  np;
        logic [IDX_W-1:0]    t11;
        logic [WEIGHT_W-1:0] t32;
        logic [SYM_W-1:0]    t8;
        ovf = 1'b0;
        guard = 0;
        while (pos < NODES && guard < 2 * NODES) begin
            guard++;
            np = pos;
            while (np + 1 < NODES && t_weight[np + 1] == t_weight[pos]) np++;
            if (np != pos && np != t_parent[pos]) begin
                if (is_leaf_node(np) && np != nyt) sym_leaf[t_symbol[np]] = IDX_W'(pos);
                else if (!is_leaf_node(np)) begin
                    if (t_left[np] < NODES) t_parent[t_left[np]] = IDX_W'(pos);
                    if (t_right[np] < NODES) t_parent[t_right[np]] = IDX_W'(pos);
                end
                if (is_leaf_node(pos) && pos != nyt) sym_leaf[t_symbol[pos]] = IDX_W'(np);
                else if (!is_leaf_node(pos)) begin
                    if (t_left[pos] < NODES) t_parent[t_left[pos]] = IDX_W'(np);
                    if (t_right[pos] < NODES) t_parent[t_right[pos]] = IDX_W'(np);
                end
                t11 = t_left[np]; t_left[np] = t_left[pos]; t_left[pos] = t11;
                t11 = t_right[np]; t_right[np] = t_right[pos]; t_right[pos] = t11;
                t32 = t_weight[np]; t_weight[np] = t_weight[pos]; t_weight[pos] = t32;
                t8 = t_symbol[np]; t_symbol[np] = t_symbol[pos]; t_symbol[pos] = t8;
                pos = np;
            end
            if (t_weight[pos] == WEIGHT_MAX) ovf = 1'b1;
            else t_weight[pos] = t_weight[pos] + 1;
            pos = t_parent[pos];
        end
        return ovf;
    endfunction

    function automatic void append_path(int pos, ref bit bits[$]);
        bit rev[$];
        int p;
        while (pos < NODES && t_parent[pos] < NODES && rev.size() < NODES) begin
            p = t_parent[pos];
            rev.push_front(t_left[p] == pos ? 1'b0 : 1'b1);
            pos = p;
        end
        foreach (rev[i]) bits.push_back(rev[i]);
    endfunction

    // Code the current tree gives a byte; with as_literal set, a known byte
    // is sent as NYT code plus raw bits anyway.
    function automatic void code_for_byte(logic [7:0] s, bit as_literal, ref bit bits[$]);
        if (sym_leaf[s] < NODES && !as_literal) append_path(sym_leaf[s], bits);
        else begin
            append_path(nyt, bits);
            for (int i = 7; i >= 0; i--) bits.push_back(s[i]);
        end
    endfunction

    function automatic void predict_encode(logic [7:0] s);
        bit      bits[$];
        bit      ovf;
        int      len;
        int      nres;
        int      pos;
        int      n;
        result_t r;
        ovf = 1'b0;
        if (sym_leaf[s] < NODES) begin
            append_path(sym_leaf[s], bits);
            ovf = update_weights(sym_leaf[s]);
        end else begin
            code_for_byte(s, 1'b1, bits);
            if (split_nyt_node(s)) ovf = update_weights(sym_leaf[s]);
        end
        len = bits.size();
        if (len > CHUNK_EFF * MAX_RESULTS) len = CHUNK_EFF * MAX_RESULTS;
        nres = (len + CHUNK_EFF - 1) / CHUNK_EFF;
        if (nres == 0) nres = 1;
        pos = 0;
        for (int k = 0; k < nres; k++) begin
            n = (len - pos < CHUNK_EFF) ? len - pos : CHUNK_EFF;
            r = '0;
            for (int i = 0; i < n; i++) r.code_bits = {r.code_bits[30:0], bits[pos + i]};
            pos += n;
            r.code_len = 6'(n);
            r.last = (k + 1 == nres);
            r.weight_overflow = ovf;
            expected_results.push_back(r);
        end
    endfunction

    function automatic void predict_decode(logic b);
        result_t          r;
        logic [IDX_W-1:0] nx;
        r = '0;
        r.last = 1'b1;
        if (in_literal) begin
            lit_shift = {lit_shift[6:0], b};
            lit_count++;
            if (lit_count >= 8) begin
                r.symbol_out = lit_shift;
                r.symbol_valid = 1'b1;
                in_literal = 1'b0;
                lit_count = '0;
                lit_shift = '0;
                walk = IDX_W'(ROOT_INDEX);
                if (sym_leaf[r.symbol_out] < NODES || split_nyt_node(r.symbol_out))
                    r.weight_overflow = update_weights(sym_leaf[r.symbol_out]);
            end
        end else begin
            nx = (walk < NODES) ? (b ? t_right[walk] : t_left[walk]) : NONE_IDX;
            if (nx >= NODES) walk = IDX_W'(ROOT_INDEX);
            else if (nx == nyt) begin
                in_literal = 1'b1;
                lit_count = '0;
                lit_shift = '0;
                walk = IDX_W'(ROOT_INDEX);
            end else if (is_leaf_node(nx)) begin
                r.symbol_out = t_symbol[nx];
                r.symbol_valid = 1'b1;
                walk = IDX_W'(ROOT_INDEX);
                r.weight_overflow = update_weights(nx);
            end else walk = nx;
        end
        expected_results.push_back(r);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk) begin
        result_t want;
        if (rst_n && result_valid && !result_stall) begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, code_len", result.code_len, 0);
            else begin
                want = expected_results.pop_front();
                if (result.code_bits !== want.code_bits)
                    report_mismatch("code_bits", result.code_bits, want.code_bits);
                if (result.code_len !== want.code_len)
                    report_mismatch("code_len", result.code_len, want.code_len);
                if (result.symbol_out !== want.symbol_out)
                    report_mismatch("symbol_out", result.symbol_out, want.symbol_out);
                if (result.symbol_valid !== want.symbol_valid)
                    report_mismatch("symbol_valid", result.symbol_valid, want.symbol_valid);
                if (result.last !== want.last)
                    report_mismatch("last", result.last, want.last);
                if (result.weight_overflow !== want.weight_overflow)
                    report_mismatch("weight_overflow", result.weight_overflow,
                                    want.weight_overflow);
            end
        end
    end

    always @(negedge clk) result_stall <= ($urandom_range(0, 99) < stall_pct);

    task automatic send_request(logic [7:0] s, logic b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= '{symbol: s, code_bit: b};
        do @(posedge clk); while (item_stall);
        if (codec_mode) predict_decode(b);
        else predict_encode(s);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_mode(logic m);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we <= 1'b0;
        codec_mode = m;
    endtask

    function automatic logic [7:0] pick_byte();
        return ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 23))
                                            : 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte_as_bits(logic [7:0] s, bit as_literal);
        bit bits[$];
        code_for_byte(s, as_literal, bits);
        foreach (bits[i]) send_request(8'($urandom), bits[i]);
    endtask

    task automatic test_directed_encode();
        logic [7:0] seq[12] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F,
                                8'h01, 8'hFE, 8'h00, 8'h55, 8'hAA, 8'h80};
        set_mode(1'b0);
        foreach (seq[i]) send_request(seq[i], 1'b1);
    endtask

    task automatic test_directed_decode();
        set_mode(1'b1);
        send_byte_as_bits(8'hFF, 1'b0);
        send_byte_as_bits(8'h3C, 1'b0);
        send_byte_as_bits(8'h00, 1'b1);
    endtask

    task automatic test_random_phase(int sidle, int rstall, int count);
        int sent;
        send_idle_pct = sidle;
        stall_pct = rstall;
        set_mode(1'b0);
        for (int i = 0; i < count / 2; i++) send_request(pick_byte(), 1'($urandom));
        set_mode(1'b1);
        sent = 0;
        while (sent < count / 2) begin
            if ($urandom_range(0, 99) < 85) begin
                bit bits[$];
                code_for_byte(pick_byte(), $urandom_range(0, 9) == 0, bits);
                foreach (bits[i]) send_request(8'($urandom), bits[i]);
                sent += bits.size();
            end else begin
                repeat ($urandom_range(1, 3)) send_request(8'($urandom), 1'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        tree_reset();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        test_directed_encode();
        test_directed_decode();
        test_random_phase(0, 0, 80);
        test_random_phase(61, 0, 80);
        test_random_phase(0, 61, 80);
        test_random_phase(26, 26, 80);
        set_mode(1'b0);
        send_idle_pct = 0;
        stall_pct = 0;
        wait_drained();
        repeat (200) @(negedge clk);
        if (mismatches == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #80ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
